FILE: rtl/wir_pkg.sv
// Shared types and constants of the wheel input report builder.
// Used by every module of the block; depends on nothing.
package wir_pkg;

    localparam int FILTER_TAPS_DEF = 4;
    localparam int SAMPLE_W        = 12;
    localparam int MUL_W           = 17;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GAIN = 3'd5;

    localparam logic [13:0] WHEEL_CENTRE = 14'h1FFF;
    localparam logic [12:0] WHEEL_SPAN   = 13'h1FFE;
    localparam logic [14:0] FULL_LOCK    = 15'd16384;
    localparam logic [7:0]  STATUS_BASE  = 8'b10011100;
    localparam logic signed [12:0] OFFSET_LIMIT = 13'sd1000;
    localparam logic [7:0]  LEVEL_MAX    = 8'd255;
    localparam logic [7:0]  PEDAL_SPAN   = 8'd255;
    localparam logic [7:0]  DIV5_RECIP   = 8'd205;

    localparam logic [3:0] HAT_N    = 4'd0;
    localparam logic [3:0] HAT_NE   = 4'd1;
    localparam logic [3:0] HAT_E    = 4'd2;
    localparam logic [3:0] HAT_SE   = 4'd3;
    localparam logic [3:0] HAT_S    = 4'd4;
    localparam logic [3:0] HAT_SW   = 4'd5;
    localparam logic [3:0] HAT_W    = 4'd6;
    localparam logic [3:0] HAT_NW   = 4'd7;
    localparam logic [3:0] HAT_NONE = 4'd8;

    typedef struct packed {
        logic [11:0] centre_x;
        logic [11:0] centre_y;
        logic [9:0]  thr_x;
        logic [9:0]  thr_y;
        logic [9:0]  neutral;
        logic [3:0]  gain;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        centre_x: 12'd2700,
        centre_y: 12'd2700,
        thr_x:    10'd400,
        thr_y:    10'd400,
        neutral:  10'd200,
        gain:     4'd1
    };

    typedef struct packed {
        logic [7:0] hat_btn;
        logic [7:0] paddle_red;
        logic [7:0] gears_btn;
        logic [7:0] wheel_lo;
        logic [7:0] wheel_hi;
        logic [7:0] throttle;
        logic [7:0] brake;
        logic [7:0] clutch;
        logic [7:0] status;
    } t_report;

endpackage

FILE: rtl/wir_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on wir_pkg for the operand width.
module wir_mul import wir_pkg::*; (
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/wir_filter.sv
// One pedal lane: sample history and its running sum.
// Depends on wir_pkg; the slot pointer comes from the top level.
module wir_filter import wir_pkg::*; #(
    parameter int TAPS = FILTER_TAPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_update,
    input  logic [$clog2(TAPS)-1:0]             i_slot,
    input  logic [SAMPLE_W-1:0]                 i_sample,
    output logic [SAMPLE_W+$clog2(TAPS)-1:0]    o_sum
);

    localparam int SUM_W = SAMPLE_W + $clog2(TAPS);

    logic [SAMPLE_W-1:0] r_hist [TAPS];
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] old_sample;

    assign old_sample = r_hist[i_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_update) begin
            r_hist[i_slot] <= i_sample;
            r_sum          <= r_sum - SUM_W'(old_sample) + SUM_W'(i_sample);
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: rtl/wir_decode.sv
// Shifter decode, hat code and report packing.
// Depends on wir_pkg for the config and report structs.
module wir_decode import wir_pkg::*; (
    input  t_cfg        i_cfg,
    input  logic [11:0] i_x_sample,
    input  logic [11:0] i_y_sample,
    input  logic [7:0]  i_wheel_buttons,
    input  logic [14:0] i_shifter_buttons,
    input  logic        i_neg,
    input  logic [12:0] i_mag,
    input  logic [7:0]  i_throttle,
    input  logic [7:0]  i_brake,
    input  logic [7:0]  i_clutch,
    output t_report     o_report
);

    function automatic logic signed [10:0] clamp_offset(input logic [11:0] s,
                                                         input logic [11:0] c);
        logic signed [12:0] d;
        d = $signed({1'b0, s}) - $signed({1'b0, c});
        if (d > OFFSET_LIMIT) begin
            d = OFFSET_LIMIT;
        end else if (d < -OFFSET_LIMIT) begin
            d = -OFFSET_LIMIT;
        end
        return d[10:0];
    endfunction

    logic signed [10:0] x;
    logic signed [10:0] y;
    logic signed [11:0] xs;
    logic signed [11:0] ys;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [11:0] tx;
    logic signed [11:0] ty;
    logic signed [11:0] nz;
    logic               down;
    logic               active;
    logic               top;
    logic               mid;
    logic               bot;
    logic               right;
    logic               left;
    logic [5:0]         gears;
    logic               reverse;
    logic [3:0]         hat;
    logic [13:0]        wheel;
    logic [7:0]         wb;
    logic [14:0]        sb;

    assign wb = i_wheel_buttons;
    assign sb = i_shifter_buttons;

    always_comb begin
        x      = clamp_offset(i_x_sample, i_cfg.centre_x);
        y      = clamp_offset(i_y_sample, i_cfg.centre_y);
        xs     = {x[10], x};
        ys     = {y[10], y};
        ax     = xs[11] ? -xs : xs;
        ay     = ys[11] ? -ys : ys;
        tx     = $signed({2'b00, i_cfg.thr_x});
        ty     = $signed({2'b00, i_cfg.thr_y});
        nz     = $signed({2'b00, i_cfg.neutral});
        down   = sb[14];
        active = !((ax < nz) && (ay < nz));
        top    = active && (ys < -ty);
        mid    = active && (ay <= ty);
        bot    = active && (ys > ty);
        right  = xs > tx;
        left   = xs < -tx;
        gears  = {bot && left && !down, bot && right, mid && left, mid && right,
                  top && left, top && right};
        reverse = bot && left && down;
        wheel  = i_neg ? (WHEEL_CENTRE - 14'(i_mag)) : (WHEEL_CENTRE + 14'(i_mag));
    end

    always_comb begin
        case (sb[3:0])
            4'h1:    hat = HAT_N;
            4'h9:    hat = HAT_NE;
            4'h8:    hat = HAT_E;
            4'hA:    hat = HAT_SE;
            4'h2:    hat = HAT_S;
            4'h6:    hat = HAT_SW;
            4'h4:    hat = HAT_W;
            4'h5:    hat = HAT_NW;
            default: hat = HAT_NONE;
        endcase
    end

    always_comb begin
        o_report.hat_btn    = {sb[7:4], hat};
        o_report.paddle_red = {sb[8], sb[9], sb[11], sb[10], wb[5], wb[2], wb[0], wb[1]};
        o_report.gears_btn  = {wb[4], wb[3], gears};
        o_report.wheel_lo   = {wheel[5:0], wb[7], wb[6]};
        o_report.wheel_hi   = wheel[13:6];
        o_report.throttle   = i_throttle;
        o_report.brake      = i_brake;
        o_report.clutch     = i_clutch;
        o_report.status     = STATUS_BASE | {1'b0, reverse, 5'b00000, down};
    end

endmodule

FILE: rtl/wheel_input_report_builder.sv
// Top level: sequencer around the shared multiplier, pedal lanes and decode.
// Depends on wir_pkg, wir_mul, wir_filter and wir_decode.
//
// One item is accepted in idle and worked through the gain, scale and
// magnitude states, then average, span, quotient and level for each pedal
// in turn, and a pack state that loads its report into the output register;
// a new item is accepted only back in idle. The single 17x17 multiplier
// serves the gain, the wheel scale, and for each pedal the tap average, the
// 0..255 scale and the divide by five. A report waiting in the output
// register does not stop the next item from being accepted; only its final
// load waits for the slot. The pedal history clears at reset.
module wheel_input_report_builder import wir_pkg::*; #(
    parameter int FILTER_TAPS = FILTER_TAPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_wheel_position,
    input  logic [11:0]           i_throttle_sample,
    input  logic [11:0]           i_brake_sample,
    input  logic [11:0]           i_clutch_sample,
    input  logic [11:0]           i_shifter_x_sample,
    input  logic [11:0]           i_shifter_y_sample,
    input  logic [7:0]            i_wheel_buttons,
    input  logic [14:0]           i_shifter_buttons,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_hat_and_shifter_buttons,
    output logic [7:0]            o_paddles_and_red_buttons,
    output logic [7:0]            o_gears_and_wheel_buttons,
    output logic [7:0]            o_wheel_low_and_buttons,
    output logic [7:0]            o_wheel_high,
    output logic [7:0]            o_throttle_level,
    output logic [7:0]            o_brake_level,
    output logic [7:0]            o_clutch_level,
    output logic [7:0]            o_status_byte,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(FILTER_TAPS);
    localparam int SUM_W  = SAMPLE_W + SLOT_W;
    localparam int AVG_SH = SUM_W + SLOT_W;
    localparam logic [MUL_W-1:0] AVG_RECIP =
        MUL_W'(((1 << AVG_SH) + FILTER_TAPS - 1) / FILTER_TAPS);

    localparam logic [1:0] PED_THROTTLE = 2'd0;
    localparam logic [1:0] PED_BRAKE    = 2'd1;
    localparam logic [1:0] PED_CLUTCH   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN,
        S_SCALE,
        S_MAG,
        S_AVG,
        S_SPAN,
        S_QUO,
        S_LVL,
        S_PACK
    } t_state;

    t_state              r_state;
    logic [1:0]          r_ped;
    logic [SLOT_W-1:0]   r_slot;
    t_cfg                r_cfg;
    logic signed [15:0]  r_pos;
    logic [11:0]         r_x;
    logic [11:0]         r_y;
    logic [7:0]          r_wb;
    logic [14:0]         r_sb;
    logic [12:0]         r_mag;
    logic [7:0]          r_q;
    logic [7:0]          r_lvl_t;
    logic [7:0]          r_lvl_b;
    logic [7:0]          r_lvl_c;
    t_report             r_report;
    logic                r_out_valid;

    logic                in_accept;
    logic [SUM_W-1:0]    sum_t;
    logic [SUM_W-1:0]    sum_b;
    logic [SUM_W-1:0]    sum_c;
    logic [SUM_W-1:0]    sum_sel;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    logic [15:0]         abs_pos;
    logic [14:0]         scaled;
    logic [SAMPLE_W-1:0] avg;
    logic [20:0]         q_sum;
    logic [7:0]          q;
    logic [5:0]          fifth;
    logic [8:0]          lvl_raw;
    logic [7:0]          lvl;
    t_report             report;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    wir_filter #(.TAPS(FILTER_TAPS)) u_filter_t (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (in_accept),
        .i_slot   (r_slot),
        .i_sample (i_throttle_sample),
        .o_sum    (sum_t)
    );

    wir_filter #(.TAPS(FILTER_TAPS)) u_filter_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (in_accept),
        .i_slot   (r_slot),
        .i_sample (i_brake_sample),
        .o_sum    (sum_b)
    );

    wir_filter #(.TAPS(FILTER_TAPS)) u_filter_c (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (in_accept),
        .i_slot   (r_slot),
        .i_sample (i_clutch_sample),
        .o_sum    (sum_c)
    );

    wir_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    wir_decode u_decode (
        .i_cfg             (r_cfg),
        .i_x_sample        (r_x),
        .i_y_sample        (r_y),
        .i_wheel_buttons   (r_wb),
        .i_shifter_buttons (r_sb),
        .i_neg             (r_pos[15]),
        .i_mag             (r_mag),
        .i_throttle        (r_lvl_t),
        .i_brake           (r_lvl_b),
        .i_clutch          (r_lvl_c),
        .o_report          (report)
    );

    always_comb begin
        abs_pos = r_pos[15] ? 16'(-r_pos) : 16'(r_pos);
        scaled  = (prod > PROD_W'(FULL_LOCK)) ? FULL_LOCK : prod[14:0];
        avg     = prod[AVG_SH +: SAMPLE_W];
        q_sum   = 21'(prod[19:0]) + 21'(prod[19:12]) + 21'd1;
        q       = q_sum[19:12];
        fifth   = prod[15:10];

        case (r_ped)
            PED_THROTTLE: sum_sel = sum_t;
            PED_BRAKE:    sum_sel = sum_b;
            default:      sum_sel = sum_c;
        endcase

        lvl_raw = 9'(r_q) + 9'(fifth) - ((r_ped == PED_THROTTLE) ? 9'd1 : 9'd0);
        if ((r_ped == PED_THROTTLE) && (r_q == 8'd0)) begin
            lvl = 8'd0;
        end else if (lvl_raw > 9'(LEVEL_MAX)) begin
            lvl = LEVEL_MAX;
        end else begin
            lvl = lvl_raw[7:0];
        end

        case (r_state)
            S_GAIN: begin
                mul_a = MUL_W'(abs_pos);
                mul_b = MUL_W'(r_cfg.gain);
            end
            S_SCALE: begin
                mul_a = MUL_W'(scaled);
                mul_b = MUL_W'(WHEEL_SPAN);
            end
            S_AVG: begin
                mul_a = MUL_W'(sum_sel);
                mul_b = AVG_RECIP;
            end
            S_SPAN: begin
                mul_a = MUL_W'(avg);
                mul_b = MUL_W'(PEDAL_SPAN);
            end
            S_QUO: begin
                mul_a = MUL_W'(q) + ((r_ped == PED_THROTTLE) ? MUL_W'(4) : MUL_W'(0));
                mul_b = MUL_W'(DIV5_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ped       <= PED_THROTTLE;
            r_slot      <= '0;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CENTRE_X:   r_cfg.centre_x <= i_cfg_data[11:0];
                    CFG_CENTRE_Y:   r_cfg.centre_y <= i_cfg_data[11:0];
                    CFG_THRESH_X:   r_cfg.thr_x    <= i_cfg_data[9:0];
                    CFG_THRESH_Y:   r_cfg.thr_y    <= i_cfg_data[9:0];
                    CFG_NEUTRAL:    r_cfg.neutral  <= i_cfg_data[9:0];
                    CFG_RANGE_GAIN: r_cfg.gain     <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_PACK)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pos   <= i_wheel_position;
                        r_x     <= i_shifter_x_sample;
                        r_y     <= i_shifter_y_sample;
                        r_wb    <= i_wheel_buttons;
                        r_sb    <= i_shifter_buttons;
                        r_slot  <= (r_slot == SLOT_W'(FILTER_TAPS - 1)) ? '0
                                                                       : r_slot + 1'b1;
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN:  r_state <= S_SCALE;
                S_SCALE: r_state <= S_MAG;
                S_MAG: begin
                    r_mag   <= prod[26:14];
                    r_ped   <= PED_THROTTLE;
                    r_state <= S_AVG;
                end
                S_AVG:   r_state <= S_SPAN;
                S_SPAN:  r_state <= S_QUO;
                S_QUO: begin
                    r_q     <= q;
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    case (r_ped)
                        PED_THROTTLE: r_lvl_t <= lvl;
                        PED_BRAKE:    r_lvl_b <= lvl;
                        default:      r_lvl_c <= lvl;
                    endcase
                    if (r_ped == PED_CLUTCH) begin
                        r_state <= S_PACK;
                    end else begin
                        r_ped   <= r_ped + 2'd1;
                        r_state <= S_AVG;
                    end
                end
                S_PACK: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_report    <= report;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid               = r_out_valid;
    assign o_hat_and_shifter_buttons = r_report.hat_btn;
    assign o_paddles_and_red_buttons = r_report.paddle_red;
    assign o_gears_and_wheel_buttons = r_report.gears_btn;
    assign o_wheel_low_and_buttons   = r_report.wheel_lo;
    assign o_wheel_high              = r_report.wheel_hi;
    assign o_throttle_level          = r_report.throttle;
    assign o_brake_level             = r_report.brake;
    assign o_clutch_level            = r_report.clutch;
    assign o_status_byte             = r_report.status;

endmodule

FILE: rtl/wir_checker.sv
// Port-level assertions for the wheel input report builder, bound to the top.
// Depends on wir_pkg for the hat code and status base constants.
module wir_checker import wir_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_hat_and_shifter_buttons,
    input logic [7:0] o_gears_and_wheel_buttons,
    input logic [7:0] o_wheel_high,
    input logic [7:0] o_throttle_level,
    input logic [7:0] o_status_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_wheel_high)
                                       && $stable(o_throttle_level))
        else $error("stalled report changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while an item is in work");

    a_status_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status_byte & 8'hBE) == STATUS_BASE)
        else $error("status byte fixed bits wrong");

    a_reverse_no_gear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_byte[6] |-> o_gears_and_wheel_buttons[5:0] == 6'd0)
        else $error("gear flag set together with reverse");

    a_hat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hat_and_shifter_buttons[3:0] <= HAT_NONE)
        else $error("hat code out of range");

endmodule

bind wheel_input_report_builder wir_checker u_wir_checker (.*);

FILE: bench/tb.sv
// Self-checking bench for wheel_input_report_builder.
// Predicts each report from the accepted ticks under random idling and stalls.
// Depends on wir_pkg and the block's RTL.
module tb;
    import wir_pkg::*;

    localparam int TAPS        = FILTER_TAPS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 82;

    typedef struct packed {
        logic [15:0] wheel;
        logic [11:0] throttle;
        logic [11:0] brake;
        logic [11:0] clutch;
        logic [11:0] shift_x;
        logic [11:0] shift_y;
        logic [7:0]  wheel_btn;
        logic [14:0] shift_btn;
    } t_tick;

    class report_scoreboard;
        t_cfg        regs;
        logic [11:0] thr_hist[TAPS];
        logic [11:0] brk_hist[TAPS];
        logic [11:0] clu_hist[TAPS];
        int          slot;
        t_report     expected_reports[$];
        int          errors;

        function new();
            regs = CFG_RESET;
            for (int i = 0; i < TAPS; i++) begin
                thr_hist[i] = '0;
                brk_hist[i] = '0;
                clu_hist[i] = '0;
            end
            slot   = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CENTRE_X:   regs.centre_x = data;
                CFG_CENTRE_Y:   regs.centre_y = data;
                CFG_THRESH_X:   regs.thr_x    = data[9:0];
                CFG_THRESH_Y:   regs.thr_y    = data[9:0];
                CFG_NEUTRAL:    regs.neutral  = data[9:0];
                CFG_RANGE_GAIN: regs.gain     = data[3:0];
                default: ;
            endcase
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int iabs(int v);
            return v < 0 ? -v : v;
        endfunction

        function void note_tick(t_tick t);
            t_report     r;
            int          s, mag, wval, x, y, tx, ty, nz;
            int          tsum, bsum, csum, tq, bq, cq, tl, bl, cl;
            logic        down, active, top, mid, bot, right, left, rev;
            logic [5:0]  gears;
            logic [3:0]  hat;
            logic [13:0] wcode;
            s    = clamp(int'($signed(t.wheel)) * int'(regs.gain), -16384, 16384);
            mag  = (iabs(s) * 8190) >>> 14;
            wval = s < 0 ? 8191 - mag : 8191 + mag;
            wcode = wval[13:0];

            thr_hist[slot] = t.throttle;
            brk_hist[slot] = t.brake;
            clu_hist[slot] = t.clutch;
            tsum = 0;
            bsum = 0;
            csum = 0;
            for (int i = 0; i < TAPS; i++) begin
                tsum += int'(thr_hist[i]);
                bsum += int'(brk_hist[i]);
                csum += int'(clu_hist[i]);
            end
            tq = (tsum / TAPS) * 255 / 4095;
            bq = (bsum / TAPS) * 255 / 4095;
            cq = (csum / TAPS) * 255 / 4095;
            tl = tq == 0 ? 0 : (12 * tq - 1) / 10;
            bl = 12 * bq / 10;
            cl = 12 * cq / 10;
            slot = (slot + 1) % TAPS;

            x  = clamp(int'(t.shift_x) - int'(regs.centre_x), -1000, 1000);
            y  = clamp(int'(t.shift_y) - int'(regs.centre_y), -1000, 1000);
            tx = int'(regs.thr_x);
            ty = int'(regs.thr_y);
            nz = int'(regs.neutral);
            down   = t.shift_btn[14];
            active = !(iabs(x) < nz && iabs(y) < nz);
            top    = active && y < -ty;
            mid    = active && iabs(y) <= ty;
            bot    = active && y > ty;
            right  = x > tx;
            left   = x < -tx;
            rev    = bot && left && down;
            gears  = {bot && left && !down, bot && right, mid && left, mid && right,
                      top && left, top && right};

            case (t.shift_btn[3:0])
                4'h1:    hat = HAT_N;
                4'h9:    hat = HAT_NE;
                4'h8:    hat = HAT_E;
                4'hA:    hat = HAT_SE;
                4'h2:    hat = HAT_S;
                4'h6:    hat = HAT_SW;
                4'h4:    hat = HAT_W;
                4'h5:    hat = HAT_NW;
                default: hat = HAT_NONE;
            endcase

            r.hat_btn    = {t.shift_btn[7:4], hat};
            r.paddle_red = {t.shift_btn[8], t.shift_btn[9], t.shift_btn[11], t.shift_btn[10],
                            t.wheel_btn[5], t.wheel_btn[2], t.wheel_btn[0], t.wheel_btn[1]};
            r.gears_btn  = {t.wheel_btn[4], t.wheel_btn[3], gears};
            r.wheel_lo   = {wcode[5:0], t.wheel_btn[7], t.wheel_btn[6]};
            r.wheel_hi   = wcode[13:6];
            r.throttle   = tl > 255 ? LEVEL_MAX : 8'(tl);
            r.brake      = bl > 255 ? LEVEL_MAX : 8'(bl);
            r.clutch     = cl > 255 ? LEVEL_MAX : 8'(cl);
            r.status     = STATUS_BASE | {1'b0, rev, 5'b0, down};
            expected_reports.push_back(r);
        endfunction

        function void compare_byte(string field, logic [7:0] exp, logic [7:0] got);
            if (got !== exp) begin
                $display("%0t mismatch %s: expected %02h actual %02h", $time, field, exp, got);
                errors++;
            end
        endfunction

        function void check_report(t_report got);
            t_report exp;
            if (expected_reports.size() == 0) begin
                $display("%0t report with none expected: actual %h", $time, got);
                errors++;
                return;
            end
            exp = expected_reports.pop_front();
            compare_byte("hat_and_shifter_buttons", exp.hat_btn,    got.hat_btn);
            compare_byte("paddles_and_red_buttons", exp.paddle_red, got.paddle_red);
            compare_byte("gears_and_wheel_buttons", exp.gears_btn,  got.gears_btn);
            compare_byte("wheel_low_and_buttons",   exp.wheel_lo,   got.wheel_lo);
            compare_byte("wheel_high",              exp.wheel_hi,   got.wheel_hi);
            compare_byte("throttle_level",          exp.throttle,   got.throttle);
            compare_byte("brake_level",             exp.brake,      got.brake);
            compare_byte("clutch_level",            exp.clutch,     got.clutch);
            compare_byte("status_byte",             exp.status,     got.status);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_tick                 drv = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_report               got;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_CENTRE_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    cycles = 0;
    bit                    no_idle = 1'b0;
    bit                    long_hold = 1'b0;

    report_scoreboard sb = new();

    wheel_input_report_builder i_dut (
        .i_clk                     (clk),
        .i_rst_n                   (rst_n),
        .i_in_valid                (in_valid),
        .o_in_stall                (in_stall),
        .i_wheel_position          (drv.wheel),
        .i_throttle_sample         (drv.throttle),
        .i_brake_sample            (drv.brake),
        .i_clutch_sample           (drv.clutch),
        .i_shifter_x_sample        (drv.shift_x),
        .i_shifter_y_sample        (drv.shift_y),
        .i_wheel_buttons           (drv.wheel_btn),
        .i_shifter_buttons         (drv.shift_btn),
        .o_out_valid               (out_valid),
        .i_out_stall               (out_stall),
        .o_hat_and_shifter_buttons (got.hat_btn),
        .o_paddles_and_red_buttons (got.paddle_red),
        .o_gears_and_wheel_buttons (got.gears_btn),
        .o_wheel_low_and_buttons   (got.wheel_lo),
        .o_wheel_high              (got.wheel_hi),
        .o_throttle_level          (got.throttle),
        .o_brake_level             (got.brake),
        .o_clutch_level            (got.clutch),
        .o_status_byte             (got.status),
        .i_cfg_valid               (cfg_valid),
        .o_cfg_ready               (cfg_ready),
        .i_cfg_index               (cfg_idx),
        .i_cfg_data                (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL wheel_input_report_builder");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) sb.note_tick(drv);
        if (rst_n && out_valid && !out_stall) sb.check_report(got);
    end

    initial begin
        int n;
        wait (rst_n === 1'b1);
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(t_cfg c);
        put_reg(CFG_CENTRE_X,   c.centre_x);
        put_reg(CFG_CENTRE_Y,   c.centre_y);
        put_reg(CFG_THRESH_X,   12'(c.thr_x));
        put_reg(CFG_THRESH_Y,   12'(c.thr_y));
        put_reg(CFG_NEUTRAL,    12'(c.neutral));
        put_reg(CFG_RANGE_GAIN, 12'(c.gain));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(t_tick t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        drv      <= t;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drain();
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    function automatic t_tick directed_tick(int k);
        int    dx[8] = '{600, -600, 600, -600, 600, -600, -600, 0};
        int    dy[8] = '{-600, -600, 0, 0, 600, 600, 600, 0};
        int    wv[8] = '{32767, -32768, 0, 16384, -16384, 1, -1, 12345};
        t_tick t;
        t.wheel     = 16'(wv[k % 8]);
        t.throttle  = k < 4 ? 12'd4095 : (k < 8 ? 12'd0 : 12'($urandom_range(0, 4095)));
        t.brake     = k < 6 ? 12'd0 : (k < 10 ? 12'd4095 : 12'($urandom_range(0, 4095)));
        t.clutch    = k % 2 ? 12'd4095 : 12'd0;
        if (k < 16) begin
            t.shift_x = 12'(2700 + dx[k % 8]);
            t.shift_y = 12'(2700 + dy[k % 8]);
        end else begin
            t.shift_x = k[0] ? 12'd4095 : 12'd0;
            t.shift_y = k[1] ? 12'd4095 : 12'd0;
        end
        t.wheel_btn = 8'h01 << (k % 8);
        t.shift_btn = 15'(k % 16) | (15'h0010 << (k % 10));
        t.shift_btn[14] = (k % 8 == 6) || (k >= 16);
        return t;
    endfunction

    function automatic logic [11:0] near_centre(logic [11:0] centre);
        int v;
        v = int'(centre) + $urandom_range(0, 2200) - 1100;
        return v < 0 ? 12'd0 : (v > 4095 ? 12'd4095 : 12'(v));
    endfunction

    function automatic logic [11:0] pedal_sample();
        case ($urandom_range(0, 3))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(3500, 4095));
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic t_tick random_tick();
        logic [3:0] hats[8] = '{4'h1, 4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5};
        t_tick t;
        case ($urandom_range(0, 3))
            0:       t.wheel = 16'($urandom);
            1:       t.wheel = 16'($urandom_range(0, 4000) - 2000);
            2:       t.wheel = 16'($urandom_range(0, 33000) - 16500);
            default: t.wheel = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
        t.throttle = pedal_sample();
        t.brake    = pedal_sample();
        t.clutch   = pedal_sample();
        if ($urandom_range(0, 3) != 0) begin
            t.shift_x = near_centre(sb.regs.centre_x);
            t.shift_y = near_centre(sb.regs.centre_y);
        end else begin
            t.shift_x = 12'($urandom);
            t.shift_y = 12'($urandom);
        end
        t.wheel_btn = 8'($urandom);
        t.shift_btn = 15'($urandom);
        if ($urandom_range(0, 1)) t.shift_btn[3:0] = hats[$urandom_range(0, 7)];
        return t;
    endfunction

    function automatic t_cfg phase_cfg(int p);
        t_cfg c;
        case (p)
            1: c = CFG_RESET;
            2: c = '{centre_x: 12'd0, centre_y: 12'd0, thr_x: 10'd0, thr_y: 10'd0,
                     neutral: 10'd0, gain: 4'd0};
            3: c = '{centre_x: 12'd4095, centre_y: 12'd4095, thr_x: 10'd1000,
                     thr_y: 10'd1000, neutral: 10'd1000, gain: 4'd15};
            4: c = '{centre_x: 12'd2048, centre_y: 12'd2048, thr_x: 10'd300,
                     thr_y: 10'd500, neutral: 10'd100, gain: 4'd2};
            default: begin
                c.centre_x = 12'($urandom);
                c.centre_y = 12'($urandom);
                c.thr_x    = 10'($urandom_range(0, 1000));
                c.thr_y    = 10'($urandom_range(0, 1000));
                c.neutral  = 10'($urandom_range(0, 1000));
                c.gain     = 4'($urandom);
            end
        endcase
        return c;
    endfunction

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(CFG_RESET);
        for (int k = 0; k < 24; k++) send_tick(directed_tick(k));
        in_valid <= 1'b0;
        for (int p = 1; p <= PHASES; p++) begin
            wait_drain();
            configure(phase_cfg(p));
            no_idle   = (p == 3);
            long_hold = (p == 4);
            for (int i = 0; i < PHASE_ITEMS; i++) send_tick(random_tick());
            in_valid <= 1'b0;
        end
        wait_drain();
        no_idle = 1'b0;
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS wheel_input_report_builder");
        end else begin
            $display("FAIL wheel_input_report_builder");
        end
        $finish;
    end

endmodule
